### rtl/tbb_pkg.sv
// ----------------------------------------------------------------------------
// tbb_pkg
// Shared types, constants and register indexes of the tilt bang-bang
// motor balance block.
// ----------------------------------------------------------------------------
package tbb_pkg;

	// field widths
	localparam int RAW_W    = 16;
	localparam int OFS_W    = 15;
	localparam int THR_W    = 8;
	localparam int DUTY_W   = 11;
	localparam int CFG_IX_W = 3;
	localparam int CFG_D_W  = 15;

	// scaled tilt: (raw + offset) * 255 >> 14, range about +-765
	localparam int SUM_W  = RAW_W + 1;
	localparam int PROD_W = SUM_W + 8;
	localparam int FRAC_W = 14;
	localparam int TILT_W = PROD_W - FRAC_W;

	// duty limits and reset values
	localparam logic [DUTY_W-1:0] DUTY_TOP    = 11'd1999;
	localparam logic [DUTY_W-1:0] LEVEL_RESET = 11'd150;
	localparam logic [THR_W-1:0]  THR_RESET   = 8'd30;
	localparam logic [DUTY_W-1:0] CENTER_RESET = 11'd150;
	localparam logic [DUTY_W-1:0] MIN_RESET   = 11'd100;
	localparam logic [DUTY_W-1:0] MAX_RESET   = 11'd200;
	localparam logic signed [OFS_W-1:0] X_OFS_RESET = 15'sd1475;
	localparam logic signed [OFS_W-1:0] Y_OFS_RESET = 15'sd0;

	// configuration register indexes
	typedef enum logic [CFG_IX_W-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_CENTER    = 3'd1,
		REG_DUTY_MIN  = 3'd2,
		REG_DUTY_MAX  = 3'd3,
		REG_X_OFFSET  = 3'd4,
		REG_Y_OFFSET  = 3'd5
	} cfg_reg_t;

	// configuration register contents
	typedef struct packed {
		logic [THR_W-1:0]         threshold;
		logic [DUTY_W-1:0]        center;
		logic [DUTY_W-1:0]        duty_min;
		logic [DUTY_W-1:0]        duty_max;
		logic signed [OFS_W-1:0]  x_offset;
		logic signed [OFS_W-1:0]  y_offset;
	} cfg_t;

	// tilt beyond the deadband on one axis
	typedef struct packed {
		logic pos;
		logic neg;
	} tilt_dir_t;

endpackage

### rtl/tbb_cfg.sv
// ----------------------------------------------------------------------------
// tbb_cfg
// Configuration register file: threshold, duty limits and axis offsets.
// ----------------------------------------------------------------------------
module tbb_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tbb_pkg::CFG_IX_W-1:0]  cfg_index,
	input  logic [tbb_pkg::CFG_D_W-1:0]   cfg_data,
	output tbb_pkg::cfg_t                 cfg
);

	tbb_pkg::cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= tbb_pkg::THR_RESET;
			cfg_q.center    <= tbb_pkg::CENTER_RESET;
			cfg_q.duty_min  <= tbb_pkg::MIN_RESET;
			cfg_q.duty_max  <= tbb_pkg::MAX_RESET;
			cfg_q.x_offset  <= tbb_pkg::X_OFS_RESET;
			cfg_q.y_offset  <= tbb_pkg::Y_OFS_RESET;
		end else if (cfg_we) begin
			unique case (tbb_pkg::cfg_reg_t'(cfg_index))
				tbb_pkg::REG_THRESHOLD: cfg_q.threshold <= cfg_data[tbb_pkg::THR_W-1:0];
				tbb_pkg::REG_CENTER:    cfg_q.center    <= cfg_data[tbb_pkg::DUTY_W-1:0];
				tbb_pkg::REG_DUTY_MIN:  cfg_q.duty_min  <= cfg_data[tbb_pkg::DUTY_W-1:0];
				tbb_pkg::REG_DUTY_MAX:  cfg_q.duty_max  <= cfg_data[tbb_pkg::DUTY_W-1:0];
				tbb_pkg::REG_X_OFFSET:  cfg_q.x_offset  <= $signed(cfg_data[tbb_pkg::OFS_W-1:0]);
				tbb_pkg::REG_Y_OFFSET:  cfg_q.y_offset  <= $signed(cfg_data[tbb_pkg::OFS_W-1:0]);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/tbb_tilt.sv
// ----------------------------------------------------------------------------
// tbb_tilt
// Scales one raw axis sample to tilt units and checks it against the
// deadband.
// ----------------------------------------------------------------------------
module tbb_tilt (
	input  logic signed [tbb_pkg::RAW_W-1:0] raw,
	input  logic signed [tbb_pkg::OFS_W-1:0] offset,
	input  logic [tbb_pkg::THR_W-1:0]        threshold,
	output tbb_pkg::tilt_dir_t               dir
);

	logic signed [tbb_pkg::SUM_W-1:0]  sum;
	logic signed [tbb_pkg::PROD_W-1:0] prod;
	logic signed [tbb_pkg::PROD_W-1:0] prod_rnd;
	logic signed [tbb_pkg::TILT_W-1:0] tilt;
	logic signed [tbb_pkg::TILT_W-1:0] thr_s;

	// sum times 255 as a shift and a subtract
	assign sum  = tbb_pkg::SUM_W'(raw) + tbb_pkg::SUM_W'(offset);
	assign prod = (tbb_pkg::PROD_W'(sum) <<< 8) - tbb_pkg::PROD_W'(sum);

	// divide by 16384 rounding toward zero: bias negatives before the shift
	assign prod_rnd = prod[tbb_pkg::PROD_W-1]
		? prod + tbb_pkg::PROD_W'((1 << tbb_pkg::FRAC_W) - 1)
		: prod;
	assign tilt = tbb_pkg::TILT_W'(prod_rnd >>> tbb_pkg::FRAC_W);

	// strict deadband compare
	assign thr_s   = $signed(tbb_pkg::TILT_W'(threshold));
	assign dir.pos = tilt > thr_s;
	assign dir.neg = tilt < -thr_s;

endmodule

### rtl/tbb_pair.sv
// ----------------------------------------------------------------------------
// tbb_pair
// Next duty levels of one motor pair when its axis is outside the deadband.
// ----------------------------------------------------------------------------
module tbb_pair (
	input  tbb_pkg::cfg_t                 cfg,
	input  logic                          fall_first,
	input  logic [tbb_pkg::DUTY_W-1:0]    rise,
	input  logic [tbb_pkg::DUTY_W-1:0]    fall,
	output logic [tbb_pkg::DUTY_W-1:0]    rise_nxt,
	output logic [tbb_pkg::DUTY_W-1:0]    fall_nxt
);

	logic [tbb_pkg::DUTY_W-1:0] rise_inc;
	logic [tbb_pkg::DUTY_W-1:0] fall_dec;
	logic [tbb_pkg::DUTY_W-1:0] center;

	// saturating steps and clamped center
	assign rise_inc = (rise >= tbb_pkg::DUTY_TOP) ? tbb_pkg::DUTY_TOP : rise + 1'b1;
	assign fall_dec = (fall == '0) ? '0 : fall - 1'b1;
	assign center   = (cfg.center > tbb_pkg::DUTY_TOP) ? tbb_pkg::DUTY_TOP : cfg.center;

	// shift one count, or push off a limit, or fall back to center
	always_comb begin
		rise_nxt = rise;
		fall_nxt = fall;
		priority if (rise < cfg.duty_max && fall > cfg.duty_min) begin
			rise_nxt = rise_inc;
			fall_nxt = fall_dec;
		end else if (fall_first && fall < cfg.duty_min) begin
			rise_nxt = rise_inc;
		end else if (rise > cfg.duty_max) begin
			fall_nxt = fall_dec;
		end else if (!fall_first && fall < cfg.duty_min) begin
			rise_nxt = rise_inc;
		end else begin
			rise_nxt = center;
			fall_nxt = center;
		end
	end

endmodule

### rtl/tilt_bang_bang_motor_balance.sv
// ----------------------------------------------------------------------------
// tilt_bang_bang_motor_balance
// Accelerometer tilt to four motor duties with a bang-bang update per sample.
// ----------------------------------------------------------------------------
// Each accepted sample lands in an input register; when the result slot is
// free or being taken, one pass of logic scales both axes, updates the
// left/right and front/back duty levels and loads them as the result, which
// waits in the level registers until taken. One sample is accepted per cycle
// while the output keeps taking results, and the rate is set by the single
// level update pass, which runs once for each word moved to the output. A new
// sample is taken while a result still waits, as long as the input register
// is free or drains in the same cycle.
module tilt_bang_bang_motor_balance (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [tbb_pkg::CFG_IX_W-1:0]        cfg_index,
	input  logic [tbb_pkg::CFG_D_W-1:0]         cfg_data,
	// samples
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [tbb_pkg::RAW_W-1:0]    accel_x_raw,
	input  logic signed [tbb_pkg::RAW_W-1:0]    accel_y_raw,
	// duties
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tbb_pkg::DUTY_W-1:0]          left_duty,
	output logic [tbb_pkg::DUTY_W-1:0]          right_duty,
	output logic [tbb_pkg::DUTY_W-1:0]          front_duty,
	output logic [tbb_pkg::DUTY_W-1:0]          back_duty
);

	tbb_pkg::cfg_t      cfg;
	tbb_pkg::tilt_dir_t ydir;
	tbb_pkg::tilt_dir_t xdir;

	logic                             valid_s1;
	logic signed [tbb_pkg::RAW_W-1:0] x_s1;
	logic signed [tbb_pkg::RAW_W-1:0] y_s1;
	logic                             out_valid_q;
	logic                             adv;

	logic [tbb_pkg::DUTY_W-1:0] left_q, right_q, front_q, back_q;
	logic [tbb_pkg::DUTY_W-1:0] y_rise, y_fall, y_rise_nxt, y_fall_nxt;
	logic [tbb_pkg::DUTY_W-1:0] x_rise, x_fall, x_rise_nxt, x_fall_nxt;

	tbb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake: input register drains whenever the result slot is free or being taken
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// sample register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_s1 <= accel_x_raw;
			y_s1 <= accel_y_raw;
		end
	end

	// tilt per axis
	tbb_tilt u_tilt_y (
		.raw       (y_s1),
		.offset    (cfg.y_offset),
		.threshold (cfg.threshold),
		.dir       (ydir)
	);

	tbb_tilt u_tilt_x (
		.raw       (x_s1),
		.offset    (cfg.x_offset),
		.threshold (cfg.threshold),
		.dir       (xdir)
	);

	// pick rising and falling motor of each pair
	assign y_rise = ydir.neg ? right_q : left_q;
	assign y_fall = ydir.neg ? left_q  : right_q;
	assign x_rise = xdir.pos ? front_q : back_q;
	assign x_fall = xdir.pos ? back_q  : front_q;

	tbb_pair u_pair_y (
		.cfg        (cfg),
		.fall_first (1'b1),
		.rise       (y_rise),
		.fall       (y_fall),
		.rise_nxt   (y_rise_nxt),
		.fall_nxt   (y_fall_nxt)
	);

	tbb_pair u_pair_x (
		.cfg        (cfg),
		.fall_first (1'b0),
		.rise       (x_rise),
		.fall       (x_fall),
		.rise_nxt   (x_rise_nxt),
		.fall_nxt   (x_fall_nxt)
	);

	// duty levels double as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= tbb_pkg::LEVEL_RESET;
			right_q <= tbb_pkg::LEVEL_RESET;
			front_q <= tbb_pkg::LEVEL_RESET;
			back_q  <= tbb_pkg::LEVEL_RESET;
		end else if (adv) begin
			if (ydir.neg) begin
				right_q <= y_rise_nxt;
				left_q  <= y_fall_nxt;
			end else if (ydir.pos) begin
				left_q  <= y_rise_nxt;
				right_q <= y_fall_nxt;
			end
			if (xdir.pos) begin
				front_q <= x_rise_nxt;
				back_q  <= x_fall_nxt;
			end else if (xdir.neg) begin
				back_q  <= x_rise_nxt;
				front_q <= x_fall_nxt;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign left_duty  = left_q;
	assign right_duty = right_q;
	assign front_duty = front_q;
	assign back_duty  = back_q;

	// levels move only when a word goes to the output
	a_levels_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({left_q, right_q, front_q, back_q}))
		else $error("duty levels changed without an update");

	// every update shows up as a valid result
	a_update_valid: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("update without a valid result");

	// levels never leave the duty range
	a_levels_range: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= tbb_pkg::DUTY_TOP && right_q <= tbb_pkg::DUTY_TOP &&
		front_q <= tbb_pkg::DUTY_TOP && back_q <= tbb_pkg::DUTY_TOP)
		else $error("duty level above top");

	// a waiting sample is never dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(x_s1) && $stable(y_s1))
		else $error("waiting sample lost");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tilt bang-bang motor balance block. A short
// directed script of samples and register writes comes first. Randomized
// phases follow under several register settings. Each duty word is checked against
// a behavioral model of the tilt scaling and level update, or the typed script word.
// ----------------------------------------------------------------------------
module tb;

	localparam int TILT_GAIN    = 255;
	localparam int ONE_G        = 16384;
	localparam int PHASES       = 6;
	localparam int PHASE_WORDS  = 175;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE       = 8;
	localparam int STALL_AT     = 400;
	localparam int STALL_LEN    = 90;
	localparam logic [tbb_pkg::CFG_IX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [tbb_pkg::CFG_IX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [tbb_pkg::DUTY_W-1:0] left;
		logic [tbb_pkg::DUTY_W-1:0] right;
		logic [tbb_pkg::DUTY_W-1:0] front;
		logic [tbb_pkg::DUTY_W-1:0] back;
	} duty_word_t;

	typedef struct {
		bit                               is_write;
		logic [tbb_pkg::CFG_IX_W-1:0]     reg_ix;
		logic [tbb_pkg::CFG_D_W-1:0]      reg_data;
		logic signed [tbb_pkg::RAW_W-1:0] x;
		logic signed [tbb_pkg::RAW_W-1:0] y;
		bit                               typed;
		duty_word_t                       want;
	} script_step_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [tbb_pkg::CFG_IX_W-1:0]     cfg_index = '0;
	logic [tbb_pkg::CFG_D_W-1:0]      cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic signed [tbb_pkg::RAW_W-1:0] accel_x_raw = '0;
	logic signed [tbb_pkg::RAW_W-1:0] accel_y_raw = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic [tbb_pkg::DUTY_W-1:0]       left_duty;
	logic [tbb_pkg::DUTY_W-1:0]       right_duty;
	logic [tbb_pkg::DUTY_W-1:0]       front_duty;
	logic [tbb_pkg::DUTY_W-1:0]       back_duty;

	// model copy of the registers and the four duty levels
	logic [tbb_pkg::THR_W-1:0]        thr_set;
	logic [tbb_pkg::DUTY_W-1:0]       center_set;
	logic [tbb_pkg::DUTY_W-1:0]       min_set;
	logic [tbb_pkg::DUTY_W-1:0]       max_set;
	logic signed [tbb_pkg::OFS_W-1:0] x_ofs_set;
	logic signed [tbb_pkg::OFS_W-1:0] y_ofs_set;
	logic [tbb_pkg::DUTY_W-1:0]       lvl_left;
	logic [tbb_pkg::DUTY_W-1:0]       lvl_right;
	logic [tbb_pkg::DUTY_W-1:0]       lvl_front;
	logic [tbb_pkg::DUTY_W-1:0]       lvl_back;

	duty_word_t pending_duties[$];
	int         err_count = 0;
	int         taken = 0;
	int         cycle_count = 0;

	tilt_bang_bang_motor_balance dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.accel_x_raw (accel_x_raw),
		.accel_y_raw (accel_y_raw),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.left_duty   (left_duty),
		.right_duty  (right_duty),
		.front_duty  (front_duty),
		.back_duty   (back_duty)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// saturating duty steps
	function automatic logic [tbb_pkg::DUTY_W-1:0] step_up(logic [tbb_pkg::DUTY_W-1:0] v);
		return (v >= tbb_pkg::DUTY_TOP) ? tbb_pkg::DUTY_TOP : v + 1'b1;
	endfunction

	function automatic logic [tbb_pkg::DUTY_W-1:0] step_down(logic [tbb_pkg::DUTY_W-1:0] v);
		return (v == '0) ? '0 : v - 1'b1;
	endfunction

	// one axis of the level update; y_order checks the falling limit first
	function automatic void bang_pair(inout logic [tbb_pkg::DUTY_W-1:0] rise,
			inout logic [tbb_pkg::DUTY_W-1:0] fall, input bit y_order);
		logic [tbb_pkg::DUTY_W-1:0] home;
		home = (center_set > tbb_pkg::DUTY_TOP) ? tbb_pkg::DUTY_TOP : center_set;
		if (rise < max_set && fall > min_set) begin
			fall = step_down(fall);
			rise = step_up(rise);
		end else if (y_order && fall < min_set) begin
			rise = step_up(rise);
		end else if (rise > max_set) begin
			fall = step_down(fall);
		end else if (!y_order && fall < min_set) begin
			rise = step_up(rise);
		end else begin
			rise = home;
			fall = home;
		end
	endfunction

	// tilt scaled by 255/16384, truncated toward zero
	function automatic int scaled_tilt(logic signed [tbb_pkg::RAW_W-1:0] raw,
			logic signed [tbb_pkg::OFS_W-1:0] ofs);
		return ((int'(raw) + int'(ofs)) * TILT_GAIN) / ONE_G;
	endfunction

	// advance the model levels by one sample, Y pair first
	function automatic duty_word_t next_duties(logic signed [tbb_pkg::RAW_W-1:0] x,
			logic signed [tbb_pkg::RAW_W-1:0] y);
		int tx;
		int ty;
		int th;
		tx = scaled_tilt(x, x_ofs_set);
		ty = scaled_tilt(y, y_ofs_set);
		th = int'(thr_set);
		if (ty < -th) begin
			bang_pair(lvl_right, lvl_left, 1'b1);
		end else if (ty > th) begin
			bang_pair(lvl_left, lvl_right, 1'b1);
		end
		if (tx > th) begin
			bang_pair(lvl_front, lvl_back, 1'b0);
		end else if (tx < -th) begin
			bang_pair(lvl_back, lvl_front, 1'b0);
		end
		return duty_word_t'{lvl_left, lvl_right, lvl_front, lvl_back};
	endfunction

	// register write as the model sees it; unused indexes do nothing
	function automatic void load_reg(logic [tbb_pkg::CFG_IX_W-1:0] ix,
			logic [tbb_pkg::CFG_D_W-1:0] d);
		case (ix)
			tbb_pkg::REG_THRESHOLD: thr_set = d[tbb_pkg::THR_W-1:0];
			tbb_pkg::REG_CENTER:    center_set = d[tbb_pkg::DUTY_W-1:0];
			tbb_pkg::REG_DUTY_MIN:  min_set = d[tbb_pkg::DUTY_W-1:0];
			tbb_pkg::REG_DUTY_MAX:  max_set = d[tbb_pkg::DUTY_W-1:0];
			tbb_pkg::REG_X_OFFSET:  x_ofs_set = d[tbb_pkg::OFS_W-1:0];
			tbb_pkg::REG_Y_OFFSET:  y_ofs_set = d[tbb_pkg::OFS_W-1:0];
			default: ;
		endcase
	endfunction

	// script rows
	function automatic script_step_t reg_row(logic [tbb_pkg::CFG_IX_W-1:0] ix,
			logic [tbb_pkg::CFG_D_W-1:0] d);
		script_step_t s;
		s.is_write = 1'b1;
		s.reg_ix = ix;
		s.reg_data = d;
		s.x = '0;
		s.y = '0;
		s.typed = 1'b0;
		s.want = '0;
		return s;
	endfunction

	function automatic script_step_t sample_row(logic signed [tbb_pkg::RAW_W-1:0] x,
			logic signed [tbb_pkg::RAW_W-1:0] y, bit typed, duty_word_t want);
		script_step_t s;
		s.is_write = 1'b0;
		s.reg_ix = '0;
		s.reg_data = '0;
		s.x = x;
		s.y = y;
		s.typed = typed;
		s.want = want;
		return s;
	endfunction

	// random axis sample: strong tilt either way, near the deadband edge, or any
	function automatic logic signed [tbb_pkg::RAW_W-1:0] axis_sample(
			logic signed [tbb_pkg::OFS_W-1:0] ofs);
		int raw;
		int tilt;
		raw = 0;
		case ($urandom_range(0, 3))
			0: raw = int'($urandom_range(12000, 32767));
			1: raw = -int'($urandom_range(12000, 32768));
			2: begin
				tilt = int'(thr_set) + int'($urandom_range(0, 3)) - 1;
				if ($urandom_range(0, 1) == 1) begin
					tilt = -tilt;
				end
				raw = tilt * ONE_G / TILT_GAIN - int'(ofs)
					+ int'($urandom_range(0, 130)) - 65;
			end
			default: raw = int'($signed(16'($urandom)));
		endcase
		if (raw > 32767) begin
			raw = 32767;
		end
		if (raw < -32768) begin
			raw = -32768;
		end
		return raw[tbb_pkg::RAW_W-1:0];
	endfunction

	// one register write, issued while the block is idle
	task automatic write_reg(input logic [tbb_pkg::CFG_IX_W-1:0] ix,
			input logic [tbb_pkg::CFG_D_W-1:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ix;
		cfg_data <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		load_reg(ix, d);
	endtask

	// stop offering and wait until every expected word has been taken
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_duties.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	// offer one sample word after a gap; record the expected duties on accept
	task automatic send_sample(input logic signed [tbb_pkg::RAW_W-1:0] x,
			input logic signed [tbb_pkg::RAW_W-1:0] y, input int gap, input bit typed,
			input duty_word_t want);
		duty_word_t model_word;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		accel_x_raw <= x;
		accel_y_raw <= y;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		model_word = next_duties(x, y);
		pending_duties.push_back(typed ? want : model_word);
	endtask

	// register setting of one random phase, extremes included
	task automatic set_phase(input int p);
		logic [tbb_pkg::THR_W-1:0]        thr;
		logic [tbb_pkg::DUTY_W-1:0]       ctr;
		logic [tbb_pkg::DUTY_W-1:0]       lo;
		logic [tbb_pkg::DUTY_W-1:0]       hi;
		logic signed [tbb_pkg::OFS_W-1:0] xo;
		logic signed [tbb_pkg::OFS_W-1:0] yo;
		case (p)
			0: begin
				thr = tbb_pkg::THR_RESET;
				ctr = tbb_pkg::CENTER_RESET;
				lo = tbb_pkg::MIN_RESET;
				hi = tbb_pkg::MAX_RESET;
				xo = tbb_pkg::X_OFS_RESET;
				yo = tbb_pkg::Y_OFS_RESET;
			end
			1: begin
				thr = 8'd0;
				ctr = 11'd1000;
				lo = 11'd990;
				hi = 11'd1010;
				xo = 15'h4000;
				yo = 15'h3FFF;
			end
			2: begin
				thr = 8'd255;
				ctr = 11'd5;
				lo = 11'd0;
				hi = 11'd10;
				xo = 15'h3FFF;
				yo = 15'h4000;
			end
			3: begin
				thr = 8'($urandom_range(0, 40));
				ctr = 11'd2047;
				lo = 11'd1990;
				hi = 11'd2047;
				xo = 15'(int'($urandom_range(0, 4000)) - 2000);
				yo = 15'(int'($urandom_range(0, 4000)) - 2000);
			end
			4: begin
				thr = 8'd10;
				ctr = 11'd0;
				lo = 11'd0;
				hi = 11'd3;
				xo = '0;
				yo = '0;
			end
			default: begin
				thr = 8'($urandom_range(0, 80));
				lo = 11'($urandom_range(0, 1990));
				hi = 11'(lo + $urandom_range(0, 40));
				ctr = 11'($urandom_range(0, 2047));
				xo = 15'($urandom);
				yo = 15'($urandom);
			end
		endcase
		drain();
		// unused upper data bits carry junk
		write_reg(tbb_pkg::REG_THRESHOLD, {7'($urandom), thr});
		write_reg(tbb_pkg::REG_CENTER, {4'($urandom), ctr});
		write_reg(tbb_pkg::REG_DUTY_MIN, {4'($urandom), lo});
		write_reg(tbb_pkg::REG_DUTY_MAX, {4'($urandom), hi});
		write_reg(tbb_pkg::REG_X_OFFSET, xo);
		write_reg(tbb_pkg::REG_Y_OFFSET, yo);
	endtask

	task automatic check_field(input string name, input logic [tbb_pkg::DUTY_W-1:0] want,
			input logic [tbb_pkg::DUTY_W-1:0] got);
		if (got !== want) begin
			err_count++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	// duty word sink with random stalls and one long hold-off
	initial begin : duty_sink
		int         hold;
		duty_word_t want;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (taken == STALL_AT) begin
				hold = STALL_LEN;
			end else if (taken % 160 < 30) begin
				hold = 0;
			end else begin
				hold = $urandom_range(0, 7);
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) begin
				@(posedge clk);
			end
			taken++;
			if (pending_duties.size() == 0) begin
				err_count++;
				$display("%0t: duty word %0d/%0d/%0d/%0d with none expected", $time,
					left_duty, right_duty, front_duty, back_duty);
			end else begin
				want = pending_duties.pop_front();
				check_field("left_duty", want.left, left_duty);
				check_field("right_duty", want.right, right_duty);
				check_field("front_duty", want.front, front_duty);
				check_field("back_duty", want.back, back_duty);
			end
		end
	end

	// reset, directed script, random phases, final check
	initial begin : stimulus
		script_step_t script[$];
		thr_set = tbb_pkg::THR_RESET;
		center_set = tbb_pkg::CENTER_RESET;
		min_set = tbb_pkg::MIN_RESET;
		max_set = tbb_pkg::MAX_RESET;
		x_ofs_set = tbb_pkg::X_OFS_RESET;
		y_ofs_set = tbb_pkg::Y_OFS_RESET;
		lvl_left = tbb_pkg::LEVEL_RESET;
		lvl_right = tbb_pkg::LEVEL_RESET;
		lvl_front = tbb_pkg::LEVEL_RESET;
		lvl_back = tbb_pkg::LEVEL_RESET;

		// levels after reset, then full-scale tilts on both axes
		script.push_back(sample_row(16'sd0, 16'sd0, 1'b1,
			duty_word_t'{11'd150, 11'd150, 11'd150, 11'd150}));
		script.push_back(sample_row(16'sd0, 16'sd32767, 1'b1,
			duty_word_t'{11'd151, 11'd149, 11'd150, 11'd150}));
		script.push_back(sample_row(16'sh8000, 16'sh8000, 1'b1,
			duty_word_t'{11'd150, 11'd150, 11'd149, 11'd151}));
		script.push_back(sample_row(16'sd32767, 16'sd32767, 1'b1,
			duty_word_t'{11'd151, 11'd149, 11'd150, 11'd150}));
		// deadband edge, and truncation toward zero on negative tilt
		script.push_back(sample_row(16'sd0, 16'sd1928, 1'b0, '0));
		script.push_back(sample_row(16'sd0, 16'sd1992, 1'b0, '0));
		script.push_back(sample_row(-16'sd3455, -16'sd1980, 1'b0, '0));
		script.push_back(sample_row(-16'sd3467, -16'sd1992, 1'b0, '0));
		// both limits met exactly: back to center
		script.push_back(reg_row(tbb_pkg::REG_DUTY_MAX, 15'd151));
		script.push_back(reg_row(tbb_pkg::REG_DUTY_MIN, 15'd149));
		script.push_back(sample_row(16'sd32767, 16'sd32767, 1'b0, '0));
		// min above max: Y and X take their limit checks in opposite order
		script.push_back(reg_row(tbb_pkg::REG_DUTY_MIN, 15'd160));
		script.push_back(reg_row(tbb_pkg::REG_DUTY_MAX, 15'd100));
		script.push_back(sample_row(16'sd32767, 16'sd32767, 1'b0, '0));
		// center above top, then increment held at top
		script.push_back(reg_row(tbb_pkg::REG_CENTER, 15'd2047));
		script.push_back(reg_row(tbb_pkg::REG_DUTY_MAX, 15'd151));
		script.push_back(reg_row(tbb_pkg::REG_DUTY_MIN, 15'd150));
		script.push_back(sample_row(16'sd0, 16'sd32767, 1'b0, '0));
		script.push_back(reg_row(tbb_pkg::REG_DUTY_MAX, 15'd2047));
		script.push_back(reg_row(tbb_pkg::REG_DUTY_MIN, 15'd0));
		script.push_back(sample_row(16'sd0, 16'sd32767, 1'b0, '0));
		// center zero, then decrement held at zero
		script.push_back(reg_row(tbb_pkg::REG_CENTER, 15'd0));
		script.push_back(reg_row(tbb_pkg::REG_DUTY_MAX, 15'd1999));
		script.push_back(reg_row(tbb_pkg::REG_DUTY_MIN, 15'd1998));
		script.push_back(sample_row(16'sd0, 16'sd32767, 1'b0, '0));
		script.push_back(reg_row(tbb_pkg::REG_DUTY_MIN, 15'd2047));
		script.push_back(sample_row(16'sd0, 16'sd32767, 1'b0, '0));
		script.push_back(reg_row(tbb_pkg::REG_DUTY_MIN, 15'd0));
		script.push_back(reg_row(tbb_pkg::REG_DUTY_MAX, 15'd0));
		script.push_back(sample_row(16'sd0, 16'sd32767, 1'b0, '0));
		// widest threshold and extreme offsets
		script.push_back(reg_row(tbb_pkg::REG_THRESHOLD, 15'd255));
		script.push_back(reg_row(tbb_pkg::REG_X_OFFSET, 15'h3FFF));
		script.push_back(reg_row(tbb_pkg::REG_Y_OFFSET, 15'h4000));
		script.push_back(sample_row(16'sd32767, 16'sh8000, 1'b0, '0));
		script.push_back(sample_row(16'sh8000, 16'sd32767, 1'b0, '0));
		// zero threshold: a tilt of one count already moves
		script.push_back(reg_row(tbb_pkg::REG_THRESHOLD, 15'd0));
		script.push_back(sample_row(-16'sd16383, 16'sd16384, 1'b0, '0));
		script.push_back(sample_row(-16'sd16318, 16'sd16449, 1'b0, '0));
		// writes past the register list are ignored
		script.push_back(reg_row(REG_SPARE_LO, 15'h7FFF));
		script.push_back(reg_row(REG_SPARE_HI, 15'h7FFF));
		script.push_back(sample_row(-16'sd1, -16'sd1, 1'b0, '0));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].is_write) begin
				drain();
				write_reg(script[i].reg_ix, script[i].reg_data);
			end else begin
				send_sample(script[i].x, script[i].y, $urandom_range(0, 7),
					script[i].typed, script[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			set_phase(p);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				send_sample(axis_sample(x_ofs_set), axis_sample(y_ofs_set),
					(n % 128 < 24) ? 0 : $urandom_range(0, 7), 1'b0, '0);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_duties.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### tilt_bang_bang_motor_balance.f
rtl/tbb_pkg.sv
rtl/tbb_cfg.sv
rtl/tbb_tilt.sv
rtl/tbb_pair.sv
rtl/tilt_bang_bang_motor_balance.sv
test/tb.sv
